// File: rtl/quaternion_vector_rotate_defines.svh
// ----------------------------------------------------------------------------
// Quaternion vector rotate assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`ifndef SYNTHESIS
`define QVR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QVR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QVR_ASSERT(label, clk, rst, prop, msg)
`define QVR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate package
// Shared constants, CORDIC arctangent table and helpers.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int DefCordicSteps = 16;
   localparam int AtanEntries    = 24;

   localparam logic signed [33:0] Q30Pi     = 34'sd3373259426;
   localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   // sqrt operand width: n2 < 2^34, shifted by 32
   localparam int SqW  = 66;
   localparam int LenW = 33;
   // division: numerator |a|*2^46 < 2^62, quotient |u| <= 2^30
   localparam int NumW = 62;
   localparam int QuoW = 31;

   function automatic logic signed [33:0] atan_q30(input int i);
      logic signed [33:0] t [AtanEntries];
      t = '{34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
            34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
            34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
            34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
            34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
            34'sd1023, 34'sd511, 34'sd255, 34'sd127};
      return t[i];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) r = 16'sh7fff;
      else if (v < -64'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   typedef struct packed {
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic               inval;
   } side_type;

endpackage

// File: rtl/qvr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate CORDIC
// Pipelined half-angle sine/cosine, one iteration per stage.
// ----------------------------------------------------------------------------
module qvr_cordic
   import qvr_pkg::*;
#(
   parameter int CORDIC_STEPS = DefCordicSteps
) (
   input  logic                clock,
   input  logic                advance,
   input  logic signed [15:0]  angle,
   output logic signed [33:0]  cos_q30,
   output logic signed [33:0]  sin_q30
);

   localparam int N = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

   logic signed [33:0] x_ff [N+1];
   logic signed [33:0] y_ff [N+1];
   logic signed [34:0] z_ff [N+1];
   logic               flip_ff [N+1];
   logic signed [34:0] z0_in;
   logic               flip0_in;

   always_comb begin
      z0_in = 35'(angle) <<< 17;
      flip0_in = 1'b0;
      if (z0_in > 35'(Q30HalfPi)) begin
         z0_in = z0_in - 35'(Q30Pi);
         flip0_in = 1'b1;
      end else if (z0_in < -35'(Q30HalfPi)) begin
         z0_in = z0_in + 35'(Q30Pi);
         flip0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= CordicGain;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         flip_ff[0] <= flip0_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_it
      always_ff @(posedge clock) begin
         if (advance) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][34]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - 35'(atan_q30(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + 35'(atan_q30(i));
            end
         end
      end
   end

   assign cos_q30 = flip_ff[N] ? -x_ff[N] : x_ff[N];
   assign sin_q30 = flip_ff[N] ? -y_ff[N] : y_ff[N];

endmodule

// File: rtl/qvr_axis_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate axis normalizer
// Pipelined bit-per-stage square root, then three restoring dividers.
// ----------------------------------------------------------------------------
module qvr_axis_norm
   import qvr_pkg::*;
(
   input  logic                clock,
   input  logic                advance,
   input  logic signed [15:0]  axis_x,
   input  logic signed [15:0]  axis_y,
   input  logic signed [15:0]  axis_z,
   output logic signed [31:0]  ux,
   output logic signed [31:0]  uy,
   output logic signed [31:0]  uz
);

   localparam int SqSteps = LenW;
   localparam int DvSteps = QuoW;
   localparam int Lat     = 3 + SqSteps + DvSteps;

   // stage 0: squares
   logic        [33:0] n2_ff;
   logic signed [15:0] a_ff [3][Lat+1];
   logic        [31:0] sq_in [3];

   always_comb begin
      sq_in[0] = 32'($signed(axis_x) * $signed(axis_x));
      sq_in[1] = 32'($signed(axis_y) * $signed(axis_y));
      sq_in[2] = 32'($signed(axis_z) * $signed(axis_z));
   end

   logic [31:0] sqa_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         sqa_ff[0] <= sq_in[0];
         sqa_ff[1] <= sq_in[1];
         sqa_ff[2] <= sq_in[2];
         n2_ff <= 34'(sqa_ff[0]) + 34'(sqa_ff[1]) + 34'(sqa_ff[2]);
         a_ff[0][0] <= axis_x;
         a_ff[1][0] <= axis_y;
         a_ff[2][0] <= axis_z;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_ad
      for (genvar s = 0; s < Lat; s++) begin : g_s
         always_ff @(posedge clock) begin
            if (advance) a_ff[k][s+1] <= a_ff[k][s];
         end
      end
   end

   // square root: one result bit per stage on rem/root
   logic [SqW-1:0]  rad_ff  [SqSteps+1];
   logic [LenW+1:0] rem_ff  [SqSteps+1];
   logic [LenW-1:0] root_ff [SqSteps+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff[0]  <= {n2_ff, 32'd0};
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < SqSteps; i++) begin : g_sq
      logic [LenW+1:0] r2;
      logic [LenW+1:0] tr;
      always_comb begin
         r2 = {rem_ff[i][LenW-1:0], rad_ff[i][SqW-1 -: 2]};
         tr = {root_ff[i], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[i+1] <= rad_ff[i] << 2;
            if (r2 >= tr) begin
               rem_ff[i+1]  <= r2 - tr;
               root_ff[i+1] <= {root_ff[i][LenW-2:0], 1'b1};
            end else begin
               rem_ff[i+1]  <= r2;
               root_ff[i+1] <= {root_ff[i][LenW-2:0], 1'b0};
            end
         end
      end
   end

   // three dividers |a|*2^46 / len, quotient one bit per stage
   for (genvar k = 0; k < 3; k++) begin : g_dv
      localparam int A0 = 2 + SqSteps;
      logic [NumW-1:0] num_ff [DvSteps+1];
      logic [LenW:0]   prem_ff [DvSteps+1];
      logic [QuoW-1:0] q_ff [DvSteps+1];
      logic [LenW-1:0] den_ff [DvSteps+1];
      logic [15:0]     mag;

      assign mag = a_ff[k][A0][15] ? 16'(-a_ff[k][A0]) : a_ff[k][A0];

      always_ff @(posedge clock) begin
         if (advance) begin
            // quotient bits 30..0 need partial remainder from bits above 30
            num_ff[0]  <= {mag, 46'd0} << (NumW - 31);
            prem_ff[0] <= (LenW+1)'({mag, 46'd0} >> 31);
            q_ff[0]    <= '0;
            den_ff[0]  <= root_ff[SqSteps];
         end
      end

      for (genvar i = 0; i < DvSteps; i++) begin : g_st
         logic [LenW+1:0] p2;
         assign p2 = {prem_ff[i], num_ff[i][NumW-1]};
         always_ff @(posedge clock) begin
            if (advance) begin
               num_ff[i+1] <= num_ff[i] << 1;
               den_ff[i+1] <= den_ff[i];
               if (p2 >= (LenW+2)'(den_ff[i])) begin
                  prem_ff[i+1] <= (LenW+1)'(p2 - (LenW+2)'(den_ff[i]));
                  q_ff[i+1]    <= {q_ff[i][QuoW-2:0], 1'b1};
               end else begin
                  prem_ff[i+1] <= (LenW+1)'(p2);
                  q_ff[i+1]    <= {q_ff[i][QuoW-2:0], 1'b0};
               end
            end
         end
      end

      logic signed [31:0] u;
      assign u = a_ff[k][Lat][15] ? -$signed({1'b0, q_ff[DvSteps]})
                                  : $signed({1'b0, q_ff[DvSteps]});
      if (k == 0) begin : g_x
         assign ux = u;
      end else if (k == 1) begin : g_y
         assign uy = u;
      end else begin : g_z
         assign uz = u;
      end
   end

endmodule

// File: rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while rsp_tready is high; the square
// root and dividers are unrolled into one bit per stage, the CORDIC into
// one step per stage. The output register plus a skid stage catch a
// beat when the receiver stalls; the whole pipeline then holds.
// Reset clears the valid bits of every stage; data registers hold.
// ----------------------------------------------------------------------------
// Quaternion vector rotate
// Rotates a Q8.8 vector by an axis-angle quaternion, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_defines.svh"
module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int CORDIC_STEPS = DefCordicSteps
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [47:0]  rsp_tdata,
   // axis_invalid
   output logic         rsp_tuser
);

   localparam int NormLat = 3 + LenW + QuoW;
   localparam int CorN    = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
   localparam int CorLat  = CorN + 1;
   localparam int FrontLat = (NormLat > CorLat) ? NormLat : CorLat;
   localparam int BackLat = 6;
   localparam int Lat = FrontLat + BackLat;

   logic advance;
   logic [Lat:0] vld_ff;
   logic skid_vld_ff;
   side_type skid_ff;
   logic [47:0] skid_dat_ff;

   // pipeline moves unless the skid is full
   assign advance    = !skid_vld_ff;
   assign req_tready = advance;

   logic signed [15:0] angle;
   assign angle = req_tdata[15:0];

   logic signed [33:0] cos_q30, sin_q30;
   logic signed [15:0] ang_dly_ff [NormLat-CorLat+1];
   logic signed [31:0] ux, uy, uz;

   // delay angle so CORDIC result lines up with the normalizer
   always_ff @(posedge clock) begin
      if (advance) ang_dly_ff[0] <= angle;
   end
   for (genvar i = 0; i < NormLat - CorLat; i++) begin : g_ad
      always_ff @(posedge clock) begin
         if (advance) ang_dly_ff[i+1] <= ang_dly_ff[i];
      end
   end

   qvr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .advance(advance),
      .angle(ang_dly_ff[NormLat-CorLat]),
      .cos_q30(cos_q30), .sin_q30(sin_q30)
   );

   qvr_axis_norm u_norm (
      .clock(clock), .advance(advance),
      .axis_x(req_tdata[31:16]), .axis_y(req_tdata[47:32]),
      .axis_z(req_tdata[63:48]),
      .ux(ux), .uy(uy), .uz(uz)
   );

   // side band delay
   side_type side_ff [NormLat+1];
   side_type side_in;
   always_comb begin
      side_in.vx = req_tdata[79:64];
      side_in.vy = req_tdata[95:80];
      side_in.vz = req_tdata[111:96];
      side_in.inval = (req_tdata[63:16] == 48'd0);
   end
   always_ff @(posedge clock) begin
      if (advance) side_ff[0] <= side_in;
   end
   for (genvar i = 0; i < NormLat; i++) begin : g_sd
      always_ff @(posedge clock) begin
         if (advance) side_ff[i+1] <= side_ff[i];
      end
   end

   // back end: b0 quaternion products, b1 floor, b2..b3 t, b4..b5 r
   logic signed [65:0] px_ff, py_ff, pz_ff;
   logic signed [33:0] c1_ff;
   logic signed [33:0] qx_ff, qy_ff, qz_ff, qw_ff;
   side_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic signed [51:0] m2_ff [12];
   logic signed [37:0] tw_ff, tx_ff, ty_ff, tz_ff;
   logic signed [73:0] m4_ff [12];
   logic signed [15:0] ox_ff, oy_ff, oz_ff;
   side_type s6_ff;
   logic signed [33:0] q3w_ff, q3x_ff, q3y_ff, q3z_ff;
   logic signed [33:0] q4w_ff, q4x_ff, q4y_ff, q4z_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= 66'(sin_q30) * 66'(ux);
         py_ff <= 66'(sin_q30) * 66'(uy);
         pz_ff <= 66'(sin_q30) * 66'(uz);
         c1_ff <= cos_q30;
         s1_ff <= side_ff[NormLat];

         qx_ff <= 34'(px_ff >>> 30);
         qy_ff <= 34'(py_ff >>> 30);
         qz_ff <= 34'(pz_ff >>> 30);
         qw_ff <= c1_ff;
         s2_ff <= s1_ff;

         m2_ff[0]  <= 52'(qx_ff) * 52'(s2_ff.vx);
         m2_ff[1]  <= 52'(qy_ff) * 52'(s2_ff.vy);
         m2_ff[2]  <= 52'(qz_ff) * 52'(s2_ff.vz);
         m2_ff[3]  <= 52'(qw_ff) * 52'(s2_ff.vx);
         m2_ff[4]  <= 52'(qy_ff) * 52'(s2_ff.vz);
         m2_ff[5]  <= 52'(qz_ff) * 52'(s2_ff.vy);
         m2_ff[6]  <= 52'(qw_ff) * 52'(s2_ff.vy);
         m2_ff[7]  <= 52'(qx_ff) * 52'(s2_ff.vz);
         m2_ff[8]  <= 52'(qz_ff) * 52'(s2_ff.vx);
         m2_ff[9]  <= 52'(qw_ff) * 52'(s2_ff.vz);
         m2_ff[10] <= 52'(qx_ff) * 52'(s2_ff.vy);
         m2_ff[11] <= 52'(qy_ff) * 52'(s2_ff.vx);
         s3_ff <= s2_ff;
         q3w_ff <= qw_ff; q3x_ff <= qx_ff; q3y_ff <= qy_ff; q3z_ff <= qz_ff;

         tw_ff <= 38'((-m2_ff[0] - m2_ff[1] - m2_ff[2]) >>> 16);
         tx_ff <= 38'((m2_ff[3] + m2_ff[4] - m2_ff[5]) >>> 16);
         ty_ff <= 38'((m2_ff[6] - m2_ff[7] + m2_ff[8]) >>> 16);
         tz_ff <= 38'((m2_ff[9] + m2_ff[10] - m2_ff[11]) >>> 16);
         s4_ff <= s3_ff;
         q4w_ff <= q3w_ff; q4x_ff <= q3x_ff; q4y_ff <= q3y_ff; q4z_ff <= q3z_ff;

         m4_ff[0]  <= 74'(tw_ff) * 74'(q4x_ff);
         m4_ff[1]  <= 74'(tx_ff) * 74'(q4w_ff);
         m4_ff[2]  <= 74'(ty_ff) * 74'(q4z_ff);
         m4_ff[3]  <= 74'(tz_ff) * 74'(q4y_ff);
         m4_ff[4]  <= 74'(tw_ff) * 74'(q4y_ff);
         m4_ff[5]  <= 74'(tx_ff) * 74'(q4z_ff);
         m4_ff[6]  <= 74'(ty_ff) * 74'(q4w_ff);
         m4_ff[7]  <= 74'(tz_ff) * 74'(q4x_ff);
         m4_ff[8]  <= 74'(tw_ff) * 74'(q4z_ff);
         m4_ff[9]  <= 74'(tx_ff) * 74'(q4y_ff);
         m4_ff[10] <= 74'(ty_ff) * 74'(q4x_ff);
         m4_ff[11] <= 74'(tz_ff) * 74'(q4w_ff);
         s5_ff <= s4_ff;

         ox_ff <= s5_ff.inval ? s5_ff.vx : sat16(64'(
            (-m4_ff[0] + m4_ff[1] - m4_ff[2] + m4_ff[3] + (74'sd1 <<< 43)) >>> 44));
         oy_ff <= s5_ff.inval ? s5_ff.vy : sat16(64'(
            (-m4_ff[4] + m4_ff[5] + m4_ff[6] - m4_ff[7] + (74'sd1 <<< 43)) >>> 44));
         oz_ff <= s5_ff.inval ? s5_ff.vz : sat16(64'(
            (-m4_ff[8] - m4_ff[9] + m4_ff[10] + m4_ff[11] + (74'sd1 <<< 43)) >>> 44));
         s6_ff <= s5_ff;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Lat-1:0], req_tvalid};
      end
   end

   // output stage: last pipeline register, skid catches it when stalled
   logic out_vld;
   assign out_vld = vld_ff[Lat];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) skid_vld_ff <= 1'b0;
      end else if (out_vld && !rsp_tready) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_ff     <= s6_ff;
         skid_dat_ff <= {oz_ff, oy_ff, ox_ff};
      end
   end

   assign rsp_tvalid = skid_vld_ff || out_vld;
   assign rsp_tdata  = skid_vld_ff ? skid_dat_ff : {oz_ff, oy_ff, ox_ff};
   assign rsp_tuser  = skid_vld_ff ? skid_ff.inval : s6_ff.inval;

   `QVR_ASSERT(a_skid_only_when_stalled, clock, reset,
      $rose(skid_vld_ff) |-> $past(!rsp_tready), "skid filled without stall")
   `QVR_ASSERT(a_no_accept_skid, clock, reset,
      skid_vld_ff |-> !req_tready, "accept while skid full")
   `QVR_ASSERT(a_skid_holds, clock, reset,
      (skid_vld_ff && !rsp_tready) |=> (skid_vld_ff && $stable(skid_dat_ff)), "skid data lost")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate testbench
// Streams axis-angle rotations through the block under idle and stall
// patterns and checks each rotated vector against a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;
   import qvr_pkg::*;

   localparam int Steps      = DefCordicSteps;
   localparam int NumRandom  = 1250;
   localparam int LatencyPad = 100;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic signed [15:0] vz;
      logic signed [15:0] vy;
      logic signed [15:0] vx;
      logic signed [15:0] az;
      logic signed [15:0] ay;
      logic signed [15:0] ax;
      logic signed [15:0] angle;
   } rotate_req_t;

   typedef struct packed {
      logic signed [15:0] rz;
      logic signed [15:0] ry;
      logic signed [15:0] rx;
      logic               inval;
   } rotated_vec_t;

   typedef struct {
      rotate_req_t  req;
      logic         known;
      rotated_vec_t want;
   } vector_row_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         rsp_tuser;

   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           cycles = 0;
   int           mismatches = 0;
   int           checked = 0;
   int           invalid_seen = 0;
   int           saturated_seen = 0;
   rotated_vec_t pending_rotations[$];

   always #1 clock = ~clock;

   quaternion_vector_rotate #(.CORDIC_STEPS(Steps)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic rotated_vec_t rotate_vector(rotate_req_t r);
      rotated_vec_t o;
      longint ax, ay, az, vx, vy, vz, len, z, x, y, dx, dy, c, s;
      longint qw, qx, qy, qz, tw, tx, ty, tz, rx, ry, rz;
      longint unsigned n2;
      bit flip;
      ax = r.ax; ay = r.ay; az = r.az;
      vx = r.vx; vy = r.vy; vz = r.vz;
      if (ax == 0 && ay == 0 && az == 0) begin
         o.rx = r.vx; o.ry = r.vy; o.rz = r.vz; o.inval = 1'b1;
         return o;
      end
      n2 = ax * ax + ay * ay + az * az;
      len = root64(n2 << 32);
      z = longint'(r.angle) * 131072;
      x = CordicGain;
      y = 0;
      flip = 0;
      if (z > Q30HalfPi) begin
         z = z - Q30Pi; flip = 1;
      end else if (z < -Q30HalfPi) begin
         z = z + Q30Pi; flip = 1;
      end
      for (int i = 0; i < Steps && i < AtanEntries; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_q30(i);
         end else begin
            x = x + dx; y = y - dy; z = z + atan_q30(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      qw = c;
      qx = floor_shift(s * ((ax * (64'sd1 <<< 46)) / len), 30);
      qy = floor_shift(s * ((ay * (64'sd1 <<< 46)) / len), 30);
      qz = floor_shift(s * ((az * (64'sd1 <<< 46)) / len), 30);
      tw = floor_shift(-qx * vx - qy * vy - qz * vz, 16);
      tx = floor_shift(qw * vx + qy * vz - qz * vy, 16);
      ty = floor_shift(qw * vy - qx * vz + qz * vx, 16);
      tz = floor_shift(qw * vz + qx * vy - qy * vx, 16);
      rx = -tw * qx + tx * qw - ty * qz + tz * qy;
      ry = -tw * qy + tx * qz + ty * qw - tz * qx;
      rz = -tw * qz - tx * qy + ty * qx + tz * qw;
      o.rx = 16'(clamp16(floor_shift(rx + (64'sd1 <<< 43), 44)));
      o.ry = 16'(clamp16(floor_shift(ry + (64'sd1 <<< 43), 44)));
      o.rz = 16'(clamp16(floor_shift(rz + (64'sd1 <<< 43), 44)));
      o.inval = 1'b0;
      return o;
   endfunction

   function automatic rotate_req_t random_request();
      rotate_req_t r;
      r = '0;
      r.angle = 16'($urandom);
      r.ax = 16'($urandom); r.ay = 16'($urandom); r.az = 16'($urandom);
      r.vx = 16'($urandom); r.vy = 16'($urandom); r.vz = 16'($urandom);
      case ($urandom_range(0, 9))
         0: begin r.ax = 0; r.ay = 0; r.az = 0; end
         1: r.angle = 16'($signed($urandom_range(0, 51472)) - 25736);
         2: begin
            r.ax = 16'($signed(17'($urandom_range(0, 6))) - 3);
            r.ay = 16'($signed(17'($urandom_range(0, 6))) - 3);
            r.az = 16'($signed(17'($urandom_range(0, 6))) - 3);
         end
         3: begin
            r.vx = 16'($signed(17'($urandom_range(0, 2048))) - 1024);
            r.vy = 16'($signed(17'($urandom_range(0, 2048))) - 1024);
            r.vz = 16'($signed(17'($urandom_range(0, 2048))) - 1024);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_beat(rotate_req_t r);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r;
      pending_rotations.push_back(rotate_vector(r));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_checked(vector_row_t row);
      if (row.known && rotate_vector(row.req) !== row.want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row angle=%0d: table %h, predictor %h",
                     row.req.angle, row.want, rotate_vector(row.req));
      end
      send_beat(row.req);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rotated_vec_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser};
         if (pending_rotations.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected beat %h", got);
         end else begin
            want = pending_rotations.pop_front();
            checked++;
            if (got.inval) invalid_seen++;
            if (got.rx == 16'sh7fff || got.rx == 16'sh8000) saturated_seen++;
            if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
                got.inval !== want.inval) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch beat %0d: expected x=%0d y=%0d z=%0d inv=%b,",
                            " got x=%0d y=%0d z=%0d inv=%b"},
                           checked, want.rx, want.ry, want.rz, want.inval,
                           got.rx, got.ry, got.rz, got.inval);
            end
         end
      end
      rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
   end

   function automatic vector_row_t row(int a, int ax, int ay, int az, int vx, int vy, int vz,
                                       bit k = 0, int rx = 0, int ry = 0, int rz = 0,
                                       bit inv = 0);
      vector_row_t t;
      t.req = '{vz: 16'(vz), vy: 16'(vy), vx: 16'(vx), az: 16'(az), ay: 16'(ay),
                ax: 16'(ax), angle: 16'(a)};
      t.known = k;
      t.want = '{rz: 16'(rz), ry: 16'(ry), rx: 16'(rx), inval: inv};
      return t;
   endfunction

   initial begin
      vector_row_t directed[$];
      int pcts_send[4] = '{0, 64, 0, 21};
      int pcts_recv[4] = '{0, 0, 64, 21};
      int wait_cycles;
      directed = '{
         row(0, 0, 0, 0, 256, -512, 1024, 1, 256, -512, 1024, 1),
         row(25736, 0, 0, 0, -32768, 32767, 0, 1, -32768, 32767, 0, 1),
         row(0, 0, 0, 1, 256, 0, 0),
         row(6434, 0, 0, 1, 256, 0, 0),
         row(-6434, 0, 1, 0, 0, 0, 256),
         row(12868, 1, 0, 0, 0, 256, 0),
         row(25736, 1, 1, 1, 100, 200, 300),
         row(-25736, -1, 2, -3, 100, 200, 300),
         row(-32768, 32767, 32767, 32767, 32767, 32767, 32767),
         row(32767, -32768, -32768, -32768, -32768, -32768, -32768),
         row(12868, -32768, 0, 0, 32767, -32768, 32767),
         row(3217, 1, 1, 0, 32767, 32767, 32767),
         row(6434, 0, 32767, 0, -32768, 0, -32768),
         row(19302, 5, -7, 11, -1, 1, -1),
         row(-1, 0, -32768, 0, 0, 0, 0),
         row(1, 0, 0, -1, 32767, -32768, 1)
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_checked(directed[i]);
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = pcts_send[p];
         recv_stall_pct = pcts_recv[p];
         for (int n = 0; n < NumRandom / 4; n++) send_beat(random_request());
      end
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (pending_rotations.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < LatencyPad) begin
         @(posedge clock);
         wait_cycles++;
      end
      $display("Checked %0d rotations over four idle/stall patterns", checked);
      $display("%0d with zero axis, %0d with saturated X, %0d mismatches",
               invalid_seen, saturated_seen, mismatches);
      if (mismatches == 0 && pending_rotations.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/qvr_pkg.sv
rtl/qvr_cordic.sv
rtl/qvr_axis_norm.sv
rtl/quaternion_vector_rotate.sv
verif/testbench.sv
